// File: rtl/bc2_pkg.sv
// ----------------------------------------------------------------------------
// bc2_pkg
// Shared types, register indexes and palette helpers of the BC2 block decoder.
// ----------------------------------------------------------------------------
package bc2_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [14:0] DIM_RESET = 15'd4;

  // reciprocal of 3 in 11 fractional bits, exact for sums up to 765
  localparam logic [9:0] RECIP3 = 10'd683;

  // one decoded block waiting for pixel output
  typedef struct packed {
    logic [3:0][23:0] palette;   // {red, green, blue} per palette code
    logic [63:0]      alpha;     // sixteen nibbles, pixel 0 lowest
    logic [31:0]      indices;   // sixteen 2-bit codes, pixel 0 lowest
    logic [11:0]      col;       // block column, low bits
    logic [11:0]      row;       // block row, low bits
    logic [15:0]      mask;      // pixels inside the image
  } entry_t;

  function automatic logic [23:0] expand565(input logic [15:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {c[15:11], c[15:13]};
    g = {c[10:5], c[10:9]};
    b = {c[4:0], c[4:2]};
    return {r, g, b};
  endfunction

  // floor((2a + b) / 3)
  function automatic logic [7:0] third_of(input logic [7:0] a, input logic [7:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = {1'b0, a, 1'b0} + {2'b00, b};
    prod = sum * RECIP3;
    return prod[18:11];
  endfunction

endpackage

// File: rtl/bc2_front.sv
// ----------------------------------------------------------------------------
// bc2_front
// Size registers, block position and palette build; writes one queue entry
// per block that has pixels inside the image.
// ----------------------------------------------------------------------------
module bc2_front #(
  parameter int unsigned MAX_DIMENSION = 16384
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [14:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     alpha_top_rows,
  input  logic [31:0]     alpha_bottom_rows,
  input  logic [15:0]     endpoint_zero,
  input  logic [15:0]     endpoint_one,
  input  logic [31:0]     colour_indices,
  input  logic            queue_ready,
  output logic            push,
  output bc2_pkg::entry_t entry
);
  import bc2_pkg::*;

  logic [14:0] image_width;
  logic [14:0] image_height;
  logic [13:0] block_column;
  logic [13:0] block_row;
  logic [13:0] block_column_next;
  logic [13:0] block_row_next;
  logic [14:0] w;
  logic [14:0] h;
  logic [3:0]  col_ok;
  logic [3:0]  row_ok;
  logic [13:0] col_inc;
  logic [13:0] row_adv;
  logic [23:0] c0;
  logic [23:0] c1;
  logic        in_fire;
  logic        cfg_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = queue_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    if (image_width == 15'd0) begin
      w = 15'd1;
    end else if ({17'd0, image_width} > 32'(MAX_DIMENSION)) begin
      w = 15'(MAX_DIMENSION);
    end else begin
      w = image_width;
    end
    if (image_height == 15'd0) begin
      h = 15'd1;
    end else if ({17'd0, image_height} > 32'(MAX_DIMENSION)) begin
      h = 15'(MAX_DIMENSION);
    end else begin
      h = image_height;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      col_ok[i] = ({1'b0, block_column, 2'b00} + 17'(i)) < {2'b00, w};
      row_ok[i] = ({1'b0, block_row, 2'b00} + 17'(i)) < {2'b00, h};
    end
  end

  // raster advance
  always_comb begin
    col_inc = block_column + 14'd1;
    if ({col_inc, 2'b00} >= {1'b0, w}) begin
      block_column_next = '0;
      row_adv           = block_row + 14'd1;
    end else begin
      block_column_next = col_inc;
      row_adv           = block_row;
    end
    if ({row_adv, 2'b00} >= {1'b0, h}) begin
      block_row_next = '0;
    end else begin
      block_row_next = row_adv;
    end
  end

  always_comb begin
    c0 = expand565(endpoint_zero);
    c1 = expand565(endpoint_one);
    entry.palette[0] = c0;
    entry.palette[1] = c1;
    entry.palette[2] = {third_of(c0[23:16], c1[23:16]),
                        third_of(c0[15:8], c1[15:8]),
                        third_of(c0[7:0], c1[7:0])};
    entry.palette[3] = {third_of(c1[23:16], c0[23:16]),
                        third_of(c1[15:8], c0[15:8]),
                        third_of(c1[7:0], c0[7:0])};
    entry.alpha   = {alpha_bottom_rows, alpha_top_rows};
    entry.indices = colour_indices;
    entry.col     = block_column[11:0];
    entry.row     = block_row[11:0];
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        entry.mask[4*j+i] = col_ok[i] && row_ok[j];
      end
    end
  end

  assign push = in_fire && (entry.mask != 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
      block_column <= '0;
      block_row    <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        block_column <= block_column_next;
        block_row    <= block_row_next;
      end
    end
  end

  a_pos_inside: assert property (@(posedge clk) disable iff (rst)
    in_fire && !cfg_fire |=> ({block_column, 2'b00} < {1'b0, w}) &&
                             ({block_row, 2'b00} < {1'b0, h}))
    else $error("block position outside image after advance");

endmodule

// File: rtl/bc2_queue.sv
// ----------------------------------------------------------------------------
// bc2_queue
// Short register queue of decoded blocks between front and back.
// ----------------------------------------------------------------------------
module bc2_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bc2_pkg::entry_t push_entry,
  output logic            ready,
  output logic            head_valid,
  output bc2_pkg::entry_t head,
  input  logic            pop
);
  import bc2_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready      = count != CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_W'(QUEUE_DEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

endmodule

// File: rtl/bc2_back.sv
// ----------------------------------------------------------------------------
// bc2_back
// Walks the inside pixels of the head block, one per cycle while the output is not
// stalled, into the output register.
// ----------------------------------------------------------------------------
module bc2_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  bc2_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic [7:0]      alpha_out,
  output logic [13:0]     pixel_x,
  output logic [13:0]     pixel_y,
  output logic            last_of_block
);
  import bc2_pkg::*;

  logic        started;
  logic [15:0] rem;
  logic [15:0] rem_eff;
  logic [15:0] rem_after;
  logic [3:0]  p;
  logic [1:0]  code;
  logic [23:0] colour;
  logic [3:0]  nib;
  logic        load;
  logic        last;

  assign load = head_valid && (!out_valid || out_ready);

  always_comb begin
    rem_eff = started ? rem : head.mask;
    p = '0;
    for (int k = 15; k >= 0; k--) begin
      if (rem_eff[k]) begin
        p = 4'(k);
      end
    end
    rem_after = rem_eff & (rem_eff - 16'd1);
    last      = rem_after == 16'd0;
    code      = head.indices[2*p +: 2];
    colour    = head.palette[code];
    nib       = head.alpha[4*p +: 4];
  end

  assign pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        started   <= !last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem           <= rem_after;
      red           <= colour[23:16];
      green         <= colour[15:8];
      blue          <= colour[7:0];
      alpha_out     <= {nib, nib};
      pixel_x       <= {head.col, p[1:0]};
      pixel_y       <= {head.row, p[3:2]};
      last_of_block <= last;
    end
  end

  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    head_valid && started |-> rem != 16'd0)
    else $error("block in progress with no pixel left");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_valid && !started |-> head.mask != 16'd0)
    else $error("empty block reached the back");

endmodule

// File: rtl/bc2_block_decoder.sv
// ----------------------------------------------------------------------------
// bc2_block_decoder
// BC2 (DXT3) texture block decoder with raster position tracking.
// ----------------------------------------------------------------------------
// usage
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes image_width
//   (index 0) and image_height (index 1); cfg_ready is always high.
//   in channel takes one compressed block per word; out channel gives one
//   RGBA8 pixel per word with its image coordinates, last_of_block on the
//   final pixel of each block. blocks fully outside the image give no pixels.
// path
//   a block is written into a queue slot; its first pixel is then loaded
//   from the queue head into the output register.
// throughput
//   one pixel per cycle while out_ready is high; a block gives as many pixel
//   words as it has pixels inside the image, 16 for an interior block, all through the single pixel output.
//   a two-block queue lets the front take new blocks while the back drains.
// reset
//   clears position to the origin, sizes to 4x4 and empties the queue.
// stall
//   when out_ready is low the output word holds; the queue then fills and
//   in_ready drops.
// ----------------------------------------------------------------------------
module bc2_block_decoder #(
  parameter int unsigned MAX_DIMENSION = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] alpha_top_rows,
  input  logic [31:0] alpha_bottom_rows,
  input  logic [15:0] endpoint_zero,
  input  logic [15:0] endpoint_one,
  input  logic [31:0] colour_indices,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha_out,
  output logic [13:0] pixel_x,
  output logic [13:0] pixel_y,
  output logic        last_of_block
);
  import bc2_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   queue_ready;
  logic   head_valid;
  logic   pop;

  bc2_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .alpha_top_rows   (alpha_top_rows),
    .alpha_bottom_rows(alpha_bottom_rows),
    .endpoint_zero    (endpoint_zero),
    .endpoint_one     (endpoint_one),
    .colour_indices   (colour_indices),
    .queue_ready      (queue_ready),
    .push             (push),
    .entry            (push_entry)
  );

  bc2_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .ready     (queue_ready),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  bc2_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha_out    (alpha_out),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_block(last_of_block)
  );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BC2 block decoder. A short directed table of
// blocks and image sizes runs first, then random phases that rewrite the
// image size while idle and stream random blocks. Both handshake sides idle at
// random, except in one run of random blocks with no gaps. Every pixel word
// is checked against a local decoder model that tracks the raster position.
// ----------------------------------------------------------------------------
module testbench;
  import bc2_pkg::*;

  localparam int unsigned MAX_DIM      = 16384;
  localparam int unsigned RAND_ITEMS   = 460;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned DIR_ROWS     = 23;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [13:0] x;
    logic [13:0] y;
    logic        last;
  } pixel_t;

  typedef struct {
    logic [14:0] w;
    logic [14:0] h;
    logic [31:0] a_top;
    logic [31:0] a_bot;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [31:0] codes;
    bit          known;
    logic [31:0] rgba;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_IMAGE_WIDTH;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] alpha_top_rows = '0;
  logic [31:0] alpha_bottom_rows = '0;
  logic [15:0] endpoint_zero = '0;
  logic [15:0] endpoint_one = '0;
  logic [31:0] colour_indices = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha_out;
  logic [13:0] pixel_x;
  logic [13:0] pixel_y;
  logic        last_of_block;

  bit          known_on = 1'b0;
  logic [31:0] known_rgba = '0;

  pixel_t      pending_pixels [$];
  int unsigned mismatches = 0;
  int unsigned gap_pct = 8;

  logic [14:0] img_w = DIM_RESET;
  logic [14:0] img_h = DIM_RESET;
  logic [13:0] blk_col = '0;
  logic [13:0] blk_row = '0;

  // rgba of known rows is {red, green, blue, alpha}
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{15'd4, 15'd4, 32'h00000000, 32'h00000000, 16'h0000, 16'h0000, 32'h00000000,
      1'b1, 32'h00000000},
    '{15'd4, 15'd4, 32'hffffffff, 32'hffffffff, 16'hffff, 16'h0000, 32'h00000000,
      1'b1, 32'hffffffff},
    '{15'd4, 15'd4, 32'h88888888, 32'h88888888, 16'h0000, 16'hffff, 32'h55555555,
      1'b1, 32'hffffff88},
    '{15'd4, 15'd4, 32'h11111111, 32'h11111111, 16'hffff, 16'h0000, 32'haaaaaaaa,
      1'b1, 32'haaaaaa11},
    '{15'd4, 15'd4, 32'h00000000, 32'h00000000, 16'hffff, 16'h0000, 32'hffffffff,
      1'b1, 32'h55555500},
    '{15'd4, 15'd4, 32'heeeeeeee, 32'heeeeeeee, 16'hf800, 16'h0000, 32'h00000000,
      1'b1, 32'hff0000ee},
    '{15'd4, 15'd4, 32'h22222222, 32'h22222222, 16'h07e0, 16'h0000, 32'h00000000,
      1'b1, 32'h00ff0022},
    '{15'd4, 15'd4, 32'h77777777, 32'h77777777, 16'h001f, 16'h0000, 32'h00000000,
      1'b1, 32'h0000ff77},
    '{15'd4, 15'd4, 32'h76543210, 32'hfedcba98, 16'h1234, 16'habcd, 32'he4e4e4e4,
      1'b0, 32'h0},
    '{15'd4, 15'd4, 32'h5a5a5a5a, 32'ha5a5a5a5, 16'hf81f, 16'h07e0, 32'h1b1b1b1b,
      1'b0, 32'h0},
    '{15'd4, 15'd4, 32'hdeadbeef, 32'h01234567, 16'h8410, 16'h7bef, 32'h39c6a5f0,
      1'b0, 32'h0},
    '{15'd5, 15'd3, 32'h0f0f0f0f, 32'hf0f0f0f0, 16'hc618, 16'h2104, 32'h9c63e41b,
      1'b0, 32'h0},
    '{15'd5, 15'd3, 32'h13579bdf, 32'h02468ace, 16'h4a69, 16'hb596, 32'h6c93a5f0,
      1'b0, 32'h0},
    '{15'd5, 15'd3, 32'hcafef00d, 32'h8badf00d, 16'h0841, 16'hf7be, 32'h0ff0c33c,
      1'b0, 32'h0},
    '{15'd0, 15'd0, 32'hffffffff, 32'hffffffff, 16'hffff, 16'h0000, 32'h00000000,
      1'b1, 32'hffffffff},
    '{15'd0, 15'd0, 32'hffffffff, 32'hffffffff, 16'hffff, 16'h0000, 32'h00000000,
      1'b1, 32'hffffffff},
    '{15'h7fff, 15'd1, 32'h89abcdef, 32'h01234567, 16'h39e7, 16'hce79, 32'hd8d8d8d8,
      1'b0, 32'h0},
    '{15'h7fff, 15'd1, 32'hfedcba98, 32'h76543210, 16'h5555, 16'haaaa, 32'h27272727,
      1'b0, 32'h0},
    '{15'd16384, 15'd16384, 32'h3c3c3c3c, 32'hc3c3c3c3, 16'h7fff, 16'h8000, 32'hb4e12d78,
      1'b0, 32'h0},
    '{15'd1, 15'd16384, 32'h12345678, 32'h9abcdef0, 16'h1111, 16'heeee, 32'h4c4c4c4c,
      1'b0, 32'h0},
    '{15'd1, 15'd16384, 32'h9abcdef0, 32'h12345678, 16'he0e0, 16'h1f1f, 32'h71717171,
      1'b0, 32'h0},
    '{15'd4, 15'd4, 32'h55555555, 32'haaaaaaaa, 16'h3333, 16'hcccc, 32'h96969696,
      1'b0, 32'h0},
    '{15'd4, 15'd4, 32'h00000000, 32'h00000000, 16'h0000, 16'h0000, 32'h00000000,
      1'b1, 32'h00000000}
  };

  bc2_block_decoder i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .alpha_top_rows    (alpha_top_rows),
    .alpha_bottom_rows (alpha_bottom_rows),
    .endpoint_zero     (endpoint_zero),
    .endpoint_one      (endpoint_one),
    .colour_indices    (colour_indices),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .red               (red),
    .green             (green),
    .blue              (blue),
    .alpha_out         (alpha_out),
    .pixel_x           (pixel_x),
    .pixel_y           (pixel_y),
    .last_of_block     (last_of_block)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [14:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic logic [23:0] widen565(input logic [15:0] c);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

  // expected pixel words of one block at the current position, then advance
  function automatic void decode_block(input logic [31:0] a_top, input logic [31:0] a_bot,
                                       input logic [15:0] c0, input logic [15:0] c1,
                                       input logic [31:0] codes, input bit known,
                                       input logic [31:0] rgba);
    int unsigned w, h, x0, y0, p, code, nib, i, j, nxt_col, nxt_row;
    int unsigned pr [4];
    int unsigned pg [4];
    int unsigned pb [4];
    logic [23:0] c;
    pixel_t      px;
    pixel_t      held;
    bit          have;
    w = clamp_dim(img_w);
    h = clamp_dim(img_h);
    c = widen565(c0);
    pr[0] = 32'(c[23:16]);
    pg[0] = 32'(c[15:8]);
    pb[0] = 32'(c[7:0]);
    c = widen565(c1);
    pr[1] = 32'(c[23:16]);
    pg[1] = 32'(c[15:8]);
    pb[1] = 32'(c[7:0]);
    pr[2] = (2 * pr[0] + pr[1]) / 3;
    pg[2] = (2 * pg[0] + pg[1]) / 3;
    pb[2] = (2 * pb[0] + pb[1]) / 3;
    pr[3] = (pr[0] + 2 * pr[1]) / 3;
    pg[3] = (pg[0] + 2 * pg[1]) / 3;
    pb[3] = (pb[0] + 2 * pb[1]) / 3;
    x0 = blk_col * 4;
    y0 = blk_row * 4;
    have = 1'b0;
    for (j = 0; j < 4; j++) begin
      for (i = 0; i < 4; i++) begin
        if (x0 + i >= w || y0 + j >= h) continue;
        p = 4 * j + i;
        code = (codes >> (2 * p)) & 32'h3;
        if (j < 2) nib = (a_top >> (4 * p)) & 32'hf;
        else nib = (a_bot >> (4 * (p - 8))) & 32'hf;
        px.red = 8'(pr[code]);
        px.green = 8'(pg[code]);
        px.blue = 8'(pb[code]);
        px.alpha = 8'(17 * nib);
        if (known) {px.red, px.green, px.blue, px.alpha} = rgba;
        px.x = 14'(x0 + i);
        px.y = 14'(y0 + j);
        px.last = 1'b0;
        if (have) pending_pixels.push_back(held);
        held = px;
        have = 1'b1;
      end
    end
    if (have) begin
      held.last = 1'b1;
      pending_pixels.push_back(held);
    end
    nxt_col = (blk_col + 1) & 32'h3fff;
    nxt_row = 32'(blk_row);
    if (nxt_col * 4 >= w) begin
      nxt_col = 0;
      nxt_row = (nxt_row + 1) & 32'h3fff;
    end
    if (nxt_row * 4 >= h) nxt_row = 0;
    blk_col = 14'(nxt_col);
    blk_row = 14'(nxt_row);
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [14:0] pick_extreme();
    case ($urandom_range(4))
      0: return 15'd0;
      1: return 15'd1;
      2: return 15'd16384;
      3: return 15'd16385;
      default: return 15'h7fff;
    endcase
  endfunction

  // scoreboard: pixel words first, then register writes, then new blocks
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      img_w = DIM_RESET;
      img_h = DIM_RESET;
      blk_col = '0;
      blk_row = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t unexpected pixel word at x %0d y %0d", $time, pixel_x, pixel_y);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("red", 32'(want.red), 32'(red));
          check_field("green", 32'(want.green), 32'(green));
          check_field("blue", 32'(want.blue), 32'(blue));
          check_field("alpha_out", 32'(want.alpha), 32'(alpha_out));
          check_field("pixel_x", 32'(want.x), 32'(pixel_x));
          check_field("pixel_y", 32'(want.y), 32'(pixel_y));
          check_field("last_of_block", 32'(want.last), 32'(last_of_block));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) img_w = cfg_data;
        else img_h = cfg_data;
      end
      if (in_valid && in_ready)
        decode_block(alpha_top_rows, alpha_bottom_rows, endpoint_zero, endpoint_one,
                     colour_indices, known_on, known_rgba);
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= gap_pct);
  end

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [14:0] w, input logic [14:0] h);
    bit width_first;
    width_first = 1'($urandom_range(1));
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= width_first ? REG_IMAGE_WIDTH : REG_IMAGE_HEIGHT;
    cfg_data <= width_first ? w : h;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= width_first ? REG_IMAGE_HEIGHT : REG_IMAGE_WIDTH;
    cfg_data <= width_first ? h : w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_block(input logic [31:0] a_top, input logic [31:0] a_bot,
                            input logic [15:0] c0, input logic [15:0] c1,
                            input logic [31:0] codes, input bit known,
                            input logic [31:0] rgba);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    alpha_top_rows <= a_top;
    alpha_bottom_rows <= a_bot;
    endpoint_zero <= c0;
    endpoint_one <= c1;
    colour_indices <= codes;
    known_on <= known;
    known_rgba <= rgba;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [14:0] cur_w, cur_h, w, h;
    logic [31:0] codes;
    int unsigned sent, nblk, k;
    cur_w = DIM_RESET;
    cur_h = DIM_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      if (dir_rows[k].w != cur_w || dir_rows[k].h != cur_h) begin
        set_size(dir_rows[k].w, dir_rows[k].h);
        cur_w = dir_rows[k].w;
        cur_h = dir_rows[k].h;
      end
      send_block(dir_rows[k].a_top, dir_rows[k].a_bot, dir_rows[k].c0, dir_rows[k].c1,
                 dir_rows[k].codes, dir_rows[k].known, dir_rows[k].rgba);
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          w = 15'($urandom_range(24, 1));
          h = 15'($urandom_range(24, 1));
        end
        6: begin
          w = 15'($urandom_range(24, 1));
          h = 15'($urandom_range(32767, 1));
        end
        7: begin
          w = 15'($urandom_range(32767));
          h = 15'($urandom_range(12, 1));
        end
        8: begin
          w = pick_extreme();
          h = pick_extreme();
        end
        default: begin
          w = 15'($urandom_range(32767));
          h = 15'($urandom_range(32767));
        end
      endcase
      set_size(w, h);
      nblk = $urandom_range(40, 5);
      repeat (nblk) begin
        gap_pct = (sent >= 150 && sent < 270) ? 0 : 8;
        case ($urandom_range(3))
          0: codes = {16{2'($urandom_range(3))}};
          default: codes = $urandom;
        endcase
        send_block($urandom, $urandom, 16'($urandom), 16'($urandom), codes, 1'b0, '0);
        sent++;
      end
    end

    wait_idle();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
